>>> rtl/core/ax25_frame_receiver_unit_defines.svh
// ============================================================================
// AX.25 frame receiver - assertion macros
// Shared property forms for the port-level checker.
// ============================================================================
`ifndef AX25_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define AX25_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset
`define AX25_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ax25 check failed");

// Next-cycle implication, masked during reset
`define AX25_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ax25 check failed");

// Next-cycle implication that also holds through reset
`define AX25_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ax25 reset check failed");

`endif

>>> rtl/core/ax25_pkg.sv
// ============================================================================
// AX.25 frame receiver - shared package
// Constants, the frame descriptor type and the FCS byte update.
// ============================================================================
package ax25_pkg;

  localparam int DEF_BUFFER_DEPTH = 64;
  localparam int DEF_MAX_PAYLOAD  = 48;

  // Wide enough for a store fill count at the largest buffer depth
  localparam int CNT_MAX_W = 9;
  // Clamped payload length, up to 63
  localparam int LEN_W     = 7;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_GOOD  = 16'hF0B8;

  // Register indexes
  localparam logic [1:0] REG_DEST_CALL = 2'd0;
  localparam logic [1:0] REG_SRC_CALL  = 2'd1;
  localparam logic [1:0] REG_PAY_OFF   = 2'd2;
  localparam logic [1:0] REG_PAY_LEN   = 2'd3;

  // Frame end descriptor handed from front to back
  typedef struct packed {
    logic                 ok;
    logic [CNT_MAX_W-1:0] count;
  } frame_desc_t;

  // CRC-16/X.25 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  v;
    c = crc_in;
    v = b;
    for (int k = 0; k < 8; k++) begin
      if ((c[0] ^ v[0]) == 1'b1) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      v = v >> 1;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/ax25_frame_receiver_unit.sv
// Result path: the closing bit pushes a descriptor into the queue; the back end takes it,
// then presents a bad-frame status, or reads each payload byte before presenting it.
// Throughput: one bit a cycle while no frame drains; a good frame then drains each
// payload byte as a store read, then a present, a bad frame 1 status transaction.
// Input is held off until the frame's results are all taken.
// Reset: synchronous active low; control and config registers return to their defaults;
// back-end data registers and the store are left as is (only this frame's bytes are read).
// ============================================================================
// AX.25 frame receiver - top level
// HDLC deframer with address match and CRC-16/X.25 check, APB configuration.
// ============================================================================
module ax25_frame_receiver_unit import ax25_pkg::*; #(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
  parameter int MAX_PAYLOAD  = DEF_MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] rx_bit, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] data_byte
  output logic        out_tuser,   // [0] frame_ok
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [47:0] dest_r;
  logic [47:0] src_r;
  logic [5:0]  poff_r;
  logic [5:0]  plen_r;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          push;
  frame_desc_t   push_desc;
  logic          pop;
  logic          q_avail;
  frame_desc_t   head;
  logic          back_busy;
  logic          bit_acc;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:3];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= 48'd194075385046676;
      src_r  <= 48'd198490611425940;
      poff_r <= 6'd20;
      plen_r <= 6'd33;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEST_CALL: dest_r <= cfg_pwdata[47:0];
        REG_SRC_CALL:  src_r  <= cfg_pwdata[47:0];
        REG_PAY_OFF:   poff_r <= cfg_pwdata[5:0];
        REG_PAY_LEN:   plen_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (reg_idx)
      REG_DEST_CALL: cfg_prdata = {16'b0, dest_r};
      REG_SRC_CALL:  cfg_prdata = {16'b0, src_r};
      REG_PAY_OFF:   cfg_prdata = {58'b0, poff_r};
      REG_PAY_LEN:   cfg_prdata = {58'b0, plen_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Hold input while a frame's results are pending
  assign in_tready = !q_avail && !back_busy;
  assign bit_acc   = in_tvalid && in_tready;

  ax25_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .bit_valid (bit_acc),
    .rx_bit    (in_tdata[0]),
    .dest_call (dest_r),
    .src_call  (src_r),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .desc_push (push),
    .desc      (push_desc)
  );

  ax25_desc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .not_empty (q_avail),
    .head      (head)
  );

  ax25_back #(.BUFFER_DEPTH(BUFFER_DEPTH), .MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .desc_avail (q_avail),
    .desc       (head),
    .desc_pop   (pop),
    .pay_off    (poff_r),
    .pay_len    (plen_r),
    .busy       (back_busy),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_ok     (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

>>> rtl/core/ax25_front.sv
// ============================================================================
// AX.25 frame receiver - bit front end
// Flag hunt, address match, destuffing, FCS and store writes, one bit a cycle.
// ============================================================================
module ax25_front import ax25_pkg::*; #(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
  localparam int AW    = $clog2(BUFFER_DEPTH),
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          bit_valid,
  input  logic          rx_bit,
  input  logic [47:0]   dest_call,
  input  logic [47:0]   src_call,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          desc_push,
  output frame_desc_t   desc
);

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_DEST = 5'b00010,
    PH_SSID = 5'b00100,
    PH_SRC  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       hunt_r, hunt_nxt;
  logic [7:0]       asm_r, asm_nxt;
  logic [2:0]       bcnt_r, bcnt_nxt;
  logic [2:0]       ones_r, ones_nxt;
  logic [2:0]       call_r, call_nxt;
  logic [CNT_W-1:0] widx_r, widx_nxt;
  logic             ovf_r, ovf_nxt;
  logic [15:0]      crc_r, crc_nxt;

  logic [7:0]  byte_in;
  logic [7:0]  hunt_sh;
  logic [7:0]  expect_b;
  logic [63:0] call_word;
  logic        store;

  assign byte_in   = {rx_bit, asm_r[7:1]};
  assign hunt_sh   = {hunt_r[6:0], rx_bit};
  assign call_word = (phase_r == PH_DEST) ? {16'b0, dest_call} : {16'b0, src_call};
  assign expect_b  = call_word[{call_r, 3'b000} +: 8];

  // Next state per accepted bit
  always_comb begin
    phase_nxt = phase_r;
    hunt_nxt  = hunt_r;
    asm_nxt   = asm_r;
    bcnt_nxt  = bcnt_r;
    ones_nxt  = ones_r;
    call_nxt  = call_r;
    widx_nxt  = widx_r;
    ovf_nxt   = ovf_r;
    crc_nxt   = crc_r;
    store     = 1'b0;
    desc_push = 1'b0;
    desc.ok    = (ovf_r == 1'b0) && (crc_r == CRC_GOOD);
    desc.count = CNT_MAX_W'(widx_r);
    if (bit_valid) begin
      case (phase_r)
        PH_DATA: begin
          if (ones_r >= 3'd5) begin
            if (rx_bit) begin
              // closing flag: report and return to hunting
              desc_push = 1'b1;
              phase_nxt = PH_HUNT;
              hunt_nxt  = 8'hFF;
              widx_nxt  = '0;
              ovf_nxt   = 1'b0;
              bcnt_nxt  = '0;
              ones_nxt  = '0;
            end else begin
              ones_nxt = '0;
            end
          end else begin
            ones_nxt = rx_bit ? ones_r + 3'd1 : 3'd0;
            asm_nxt  = byte_in;
            bcnt_nxt = bcnt_r + 3'd1;
            store    = (bcnt_r == 3'd7);
          end
        end
        PH_DEST, PH_SSID, PH_SRC: begin
          asm_nxt  = byte_in;
          bcnt_nxt = bcnt_r + 3'd1;
          if (bcnt_r == 3'd7) begin
            if (phase_r == PH_SSID) begin
              store     = 1'b1;
              phase_nxt = PH_SRC;
              call_nxt  = '0;
            end else if (phase_r == PH_DEST && call_r == 3'd0 && byte_in == FLAG_BYTE) begin
              // skip repeated opening flags
            end else if (byte_in != expect_b || call_r > 3'd5) begin
              // address mismatch: drop; a flag opens a new frame, other bytes become the hunt window
              if (byte_in == FLAG_BYTE) begin
                phase_nxt = PH_DEST;
                call_nxt  = '0;
                widx_nxt  = '0;
                ovf_nxt   = 1'b0;
                crc_nxt   = CRC_INIT;
                bcnt_nxt  = '0;
                ones_nxt  = '0;
                asm_nxt   = '0;
              end else begin
                phase_nxt = PH_HUNT;
                hunt_nxt  = byte_in;
              end
            end else begin
              store = 1'b1;
              if (call_r == 3'd5) begin
                call_nxt = '0;
                if (phase_r == PH_DEST) begin
                  phase_nxt = PH_SSID;
                end else begin
                  phase_nxt = PH_DATA;
                  ones_nxt  = '0;
                  bcnt_nxt  = '0;
                  asm_nxt   = '0;
                end
              end else begin
                call_nxt = call_r + 3'd1;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          hunt_nxt  = hunt_sh;
          if (hunt_sh == FLAG_BYTE) begin
            phase_nxt = PH_DEST;
            call_nxt  = '0;
            widx_nxt  = '0;
            ovf_nxt   = 1'b0;
            crc_nxt   = CRC_INIT;
            bcnt_nxt  = '0;
            ones_nxt  = '0;
            asm_nxt   = '0;
          end
        end
      endcase
      // store the completed byte while there is room and fold it into the FCS
      if (store) begin
        crc_nxt = crc_byte(crc_r, byte_in);
        if (widx_r < CNT_W'(BUFFER_DEPTH)) begin
          widx_nxt = widx_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  assign wr_en   = store && (widx_r < CNT_W'(BUFFER_DEPTH));
  assign wr_addr = widx_r[AW-1:0];
  assign wr_data = byte_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      hunt_r  <= 8'hFF;
      asm_r   <= '0;
      bcnt_r  <= '0;
      ones_r  <= '0;
      call_r  <= '0;
      widx_r  <= '0;
      ovf_r   <= 1'b0;
      crc_r   <= CRC_INIT;
    end else begin
      phase_r <= phase_nxt;
      hunt_r  <= hunt_nxt;
      asm_r   <= asm_nxt;
      bcnt_r  <= bcnt_nxt;
      ones_r  <= ones_nxt;
      call_r  <= call_nxt;
      widx_r  <= widx_nxt;
      ovf_r   <= ovf_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

>>> rtl/core/ax25_desc_fifo.sv
// ============================================================================
// AX.25 frame receiver - descriptor queue
// Two-entry queue of frame end descriptors between front and back.
// ============================================================================
module ax25_desc_fifo import ax25_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_desc_t push_desc,
  input  logic        pop,
  output logic        not_empty,
  output frame_desc_t head
);

  frame_desc_t ent_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rptr_r];

  // Advance pointers and fill level
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push && cnt_r != 2'd2) begin
      wptr_nxt = ~wptr_r;
      cnt_nxt  = cnt_nxt + 2'd1;
    end
    if (pop && not_empty) begin
      rptr_nxt = ~rptr_r;
      cnt_nxt  = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && cnt_r != 2'd2) begin
      ent_r[wptr_r] <= push_desc;
    end
  end

endmodule

>>> rtl/core/ax25_back.sv
// ============================================================================
// AX.25 frame receiver - payload back end
// Holds the frame store and drains payload or status transactions.
// ============================================================================
module ax25_back import ax25_pkg::*; #(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
  parameter int MAX_PAYLOAD  = DEF_MAX_PAYLOAD,
  localparam int AW    = $clog2(BUFFER_DEPTH),
  localparam int IDX_W = CNT_MAX_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          desc_avail,
  input  frame_desc_t   desc,
  output logic          desc_pop,
  input  logic [5:0]    pay_off,
  input  logic [5:0]    pay_len,
  output logic          busy,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_ok,
  output logic          out_last
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_EMIT = 3'b100
  } bk_state_t;

  logic [7:0] store_mem [BUFFER_DEPTH];

  bk_state_t      st_r, st_nxt;
  logic [LEN_W-1:0] i_r, i_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic           ok_r, ok_nxt;
  logic           last_r, last_nxt;
  logic           inr_r, inr_nxt;
  logic [7:0]     byte_r;
  logic [LEN_W-1:0] len_clamp;
  logic [IDX_W-1:0] idx;

  assign len_clamp = (LEN_W'(pay_len) > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                             : LEN_W'(pay_len);
  assign idx       = IDX_W'(pay_off) + IDX_W'(i_r);
  assign busy      = (st_r != BK_IDLE);
  assign desc_pop  = (st_r == BK_IDLE) && desc_avail;
  assign out_valid = (st_r == BK_EMIT);
  assign out_byte  = inr_r ? byte_r : 8'h00;
  assign out_ok    = ok_r;
  assign out_last  = last_r;

  // Take a descriptor; read a byte, present it, repeat; bad frame: one status
  always_comb begin
    st_nxt   = st_r;
    i_nxt    = i_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    ok_nxt   = ok_r;
    last_nxt = last_r;
    inr_nxt  = inr_r;
    case (st_r)
      BK_IDLE: begin
        if (desc_avail) begin
          cnt_nxt = desc.count;
          ok_nxt  = desc.ok;
          if (!desc.ok) begin
            inr_nxt  = 1'b0;
            last_nxt = 1'b1;
            st_nxt   = BK_EMIT;
          end else if (len_clamp != '0) begin
            len_nxt = len_clamp;
            i_nxt   = '0;
            st_nxt  = BK_READ;
          end
        end
      end
      BK_READ: begin
        inr_nxt  = (idx < cnt_r);
        last_nxt = (i_r + LEN_W'(1) == len_r);
        st_nxt   = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_ready) begin
          if (last_r) begin
            st_nxt = BK_IDLE;
          end else begin
            i_nxt  = i_r + LEN_W'(1);
            st_nxt = BK_READ;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    len_r  <= len_nxt;
    cnt_r  <= cnt_nxt;
    ok_r   <= ok_nxt;
    last_r <= last_nxt;
    inr_r  <= inr_nxt;
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (st_r == BK_READ) begin
      byte_r <= store_mem[idx[AW-1:0]];
    end
  end

endmodule

>>> rtl/core/ax25_checker.sv
// ============================================================================
// AX.25 frame receiver - port checker
// Watches the top level's ports and flags behaviour the design must not show.
// ============================================================================
`include "ax25_frame_receiver_unit_defines.svh"

module ax25_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast,
  input logic       cfg_pready
);

  // no result straight out of reset
  `AX25_ASSERT_RST(a_rst_quiet, clk, !rst_n, !out_tvalid)
  // input held off while a result is on offer
  `AX25_ASSERT_NOW(a_hold_in, clk, rst_n, out_tvalid, !in_tready)
  // a bad-frame status is a single zero transaction
  `AX25_ASSERT_NOW(a_bad_status, clk, rst_n, out_tvalid && !out_tuser,
                   out_tlast && out_tdata == 8'h00)
  // an offered result stays until taken
  `AX25_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // configuration port never waits
  `AX25_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_pready)

endmodule

bind ax25_frame_receiver_unit ax25_checker u_ax25_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

>>> sim/ax25_frame_checker.sv
// ----------------------------------------------------------------------------
// AX.25 frame receiver - transaction checker
// Watches the bit, result and register ports, predicts each frame's result
// transactions and compares them field by field in order of arrival.
// ----------------------------------------------------------------------------
module ax25_frame_checker import ax25_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] rx_bit, [7:1] zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,   // [7:0] data_byte
  input  logic        out_tuser,   // [0] frame_ok
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 64;
  localparam int PAYLOAD_CAP = 48;

  typedef enum logic [2:0] {
    ST_HUNT = 3'd0,
    ST_DEST = 3'd1,
    ST_SSID = 3'd2,
    ST_SRC  = 3'd3,
    ST_DATA = 3'd4
  } rx_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       ok;
    logic       last;
  } payload_beat_t;

  payload_beat_t payload_q[$];

  logic [47:0] want_dest;
  logic [47:0] want_src;
  logic [5:0]  pay_off;
  logic [5:0]  pay_len;

  rx_phase_t   ph;
  logic [7:0]  hunt;
  logic [7:0]  asm_b;
  int          bitc;
  int          ones;
  int          cidx;
  int          widx;
  bit          ovf;
  logic [7:0]  store [STORE_DEPTH];
  logic [15:0] fcs;
  int          errs;
  int          seen;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    errs         = 0;
    seen         = 0;
  end

  task automatic restart_frame();
    ph    = ST_DEST;
    cidx  = 0;
    widx  = 0;
    ovf   = 1'b0;
    fcs   = 16'hFFFF;
    bitc  = 0;
    ones  = 0;
    asm_b = 8'h00;
  endtask

  // Fold the byte into the FCS and keep it while there is room
  task automatic keep_byte(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    for (int k = 0; k < 8; k++) begin
      if (fcs[0] ^ v[0]) begin
        fcs = (fcs >> 1) ^ 16'h8408;
      end else begin
        fcs = fcs >> 1;
      end
      v = v >> 1;
    end
    if (widx < STORE_DEPTH) begin
      store[widx] = b;
      widx++;
    end else begin
      ovf = 1'b1;
    end
  endtask

  // Queue the payload of a good frame, or one status beat for a bad one
  task automatic close_frame();
    int            len;
    int            idx;
    payload_beat_t beat;
    ph   = ST_HUNT;
    hunt = 8'hFF;
    if (ovf || fcs != CRC_GOOD) begin
      beat = '{data: 8'h00, ok: 1'b0, last: 1'b1};
      payload_q.push_back(beat);
    end else begin
      len = (pay_len > PAYLOAD_CAP) ? PAYLOAD_CAP : pay_len;
      for (int i = 0; i < len; i++) begin
        idx = pay_off + i;
        beat.data = (idx < widx) ? store[idx] : 8'h00;
        beat.ok   = 1'b1;
        beat.last = (i + 1 == len);
        payload_q.push_back(beat);
      end
    end
    widx = 0;
    ovf  = 1'b0;
    bitc = 0;
    ones = 0;
  endtask

  task automatic take_bit(input logic b);
    logic [7:0] got;
    logic [7:0] want;
    // Destuffed data: after five ones a zero is dropped and a one closes the frame
    if (ph == ST_DATA) begin
      if (ones >= 5) begin
        if (b) begin
          close_frame();
        end else begin
          ones = 0;
        end
        return;
      end
      ones  = b ? ones + 1 : 0;
      asm_b = {b, asm_b[7:1]};
      bitc  = (bitc + 1) % 8;
      if (bitc == 0) keep_byte(asm_b);
      return;
    end
    // Hunt for the opening flag in a sliding window
    if (ph != ST_DEST && ph != ST_SSID && ph != ST_SRC) begin
      ph   = ST_HUNT;
      hunt = {hunt[6:0], b};
      if (hunt == FLAG_BYTE) restart_frame();
      return;
    end
    asm_b = {b, asm_b[7:1]};
    bitc  = (bitc + 1) % 8;
    if (bitc != 0) return;
    got = asm_b;
    if (ph == ST_SSID) begin
      keep_byte(got);
      ph   = ST_SRC;
      cidx = 0;
      return;
    end
    if (ph == ST_DEST) begin
      // Skip repeated flags ahead of the first address byte
      if (cidx == 0 && got == FLAG_BYTE) return;
      want = want_dest[cidx*8 +: 8];
    end else begin
      want = want_src[cidx*8 +: 8];
    end
    // Drop on mismatch; a mismatching flag opens a new frame
    if (got != want) begin
      if (got == FLAG_BYTE) begin
        restart_frame();
      end else begin
        ph   = ST_HUNT;
        hunt = got;
      end
      return;
    end
    keep_byte(got);
    cidx++;
    if (cidx == 6) begin
      cidx = 0;
      if (ph == ST_DEST) begin
        ph = ST_SSID;
      end else begin
        ph    = ST_DATA;
        ones  = 0;
        bitc  = 0;
        asm_b = 8'h00;
      end
    end
  endtask

  always @(posedge clk) begin
    payload_beat_t exp_b;
    if (!rst_n) begin
      want_dest = 48'd194075385046676;
      want_src  = 48'd198490611425940;
      pay_off   = 6'd20;
      pay_len   = 6'd33;
      ph        = ST_HUNT;
      hunt      = 8'hFF;
      asm_b     = 8'h00;
      bitc      = 0;
      ones      = 0;
      cidx      = 0;
      widx      = 0;
      ovf       = 1'b0;
      fcs       = 16'hFFFF;
      payload_q.delete();
    end else begin
      // Track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_DEST_CALL: want_dest = cfg_pwdata[47:0];
          REG_SRC_CALL:  want_src  = cfg_pwdata[47:0];
          REG_PAY_OFF:   pay_off   = cfg_pwdata[5:0];
          REG_PAY_LEN:   pay_len   = cfg_pwdata[5:0];
          default: ;
        endcase
      end
      // Compare each result transaction with the oldest expected one
      if (out_tvalid && out_tready) begin
        seen++;
        if (payload_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result data=%02h ok=%b last=%b", $time,
                   out_tdata, out_tuser, out_tlast);
        end else begin
          exp_b = payload_q.pop_front();
          if (out_tdata !== exp_b.data) begin
            errs++;
            $display("%0t: data_byte expected %02h actual %02h", $time, exp_b.data,
                     out_tdata);
          end
          if (out_tuser !== exp_b.ok) begin
            errs++;
            $display("%0t: frame_ok expected %b actual %b", $time, exp_b.ok, out_tuser);
          end
          if (out_tlast !== exp_b.last) begin
            errs++;
            $display("%0t: last expected %b actual %b", $time, exp_b.last, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) take_bit(in_tdata[0]);
    end
    pending      <= payload_q.size();
    fail_count   <= errs;
    results_seen <= seen;
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// AX.25 frame receiver - testbench top
// Builds bit streams of whole frames (good, bad FCS, address mismatches,
// repeated flags, partial bytes, noise) under several register settings,
// with random idling on both channels; the checker judges results.
// ----------------------------------------------------------------------------
module testbench import ax25_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  typedef enum int {
    FR_GOOD,
    FR_BAD_FCS,
    FR_BAD_DEST,
    FR_BAD_SRC,
    FR_FLAG_IN_ADDR,
    FR_PARTIAL
  } frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = 5'd0;
  logic [63:0] cfg_pwdata = 64'd0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  int          fail_count;
  int          pending;
  int          results_seen;

  bit          idle_on = 1'b1;
  int          cycles = 0;
  int          stall_left = 0;
  int          stuff_ones;
  logic        line_q[$];
  logic [47:0] cur_dest = 48'd194075385046676;
  logic [47:0] cur_src  = 48'd198490611425940;

  ax25_frame_receiver_unit dut (.*);

  ax25_frame_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending, .results_seen
  );

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[ax25_frame_receiver_unit] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic put_raw(input logic [7:0] b);
    for (int k = 0; k < 8; k++) line_q.push_back(b[k]);
  endtask

  // Insert a zero after every run of five ones
  task automatic put_stuffed_bit(input logic b);
    line_q.push_back(b);
    if (b) begin
      stuff_ones++;
      if (stuff_ones == 5) begin
        line_q.push_back(1'b0);
        stuff_ones = 0;
      end
    end else begin
      stuff_ones = 0;
    end
  endtask

  function automatic logic [15:0] fcs_add(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ b[k]) ? ((r >> 1) ^ 16'h8408) : (r >> 1);
    end
    return r;
  endfunction

  task automatic build_frame(input frame_kind_t kind, input int nflags, input int ndata);
    logic [15:0] c;
    logic [7:0]  b;
    int          bad_at;
    c      = 16'hFFFF;
    bad_at = $urandom_range(0, 5);
    for (int f = 0; f < nflags; f++) put_raw(FLAG_BYTE);
    // A flag met in place of the second address byte opens a new frame
    if (kind == FR_FLAG_IN_ADDR && cur_dest[15:8] != FLAG_BYTE) begin
      put_raw(cur_dest[7:0]);
      put_raw(FLAG_BYTE);
    end
    for (int i = 0; i < 6; i++) begin
      b = cur_dest[i*8 +: 8];
      if (kind == FR_BAD_DEST && i == bad_at) b ^= 8'h01 << $urandom_range(0, 7);
      put_raw(b);
      c = fcs_add(c, b);
    end
    b = 8'($urandom);
    put_raw(b);
    c = fcs_add(c, b);
    for (int i = 0; i < 6; i++) begin
      b = cur_src[i*8 +: 8];
      if (kind == FR_BAD_SRC && i == bad_at) b ^= 8'h01 << $urandom_range(0, 7);
      put_raw(b);
      c = fcs_add(c, b);
    end
    stuff_ones = 0;
    for (int i = 0; i < ndata; i++) begin
      b = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      for (int k = 0; k < 8; k++) put_stuffed_bit(b[k]);
      c = fcs_add(c, b);
    end
    c = ~c;
    if (kind == FR_BAD_FCS) c ^= 16'h1 << $urandom_range(0, 15);
    for (int k = 0; k < 16; k++) put_stuffed_bit(c[k]);
    if (kind == FR_PARTIAL) begin
      for (int k = $urandom_range(1, 7); k > 0; k--) begin
        put_stuffed_bit(1'($urandom_range(0, 1)));
      end
    end
    put_raw(FLAG_BYTE);
  endtask

  task automatic put_noise(input int n);
    for (int k = 0; k < n; k++) line_q.push_back(1'($urandom_range(0, 1)));
  endtask

  // Drive every queued bit as one input transaction each
  task automatic send_line();
    while (line_q.size() > 0) begin
      if (idle_on && $urandom_range(0, 15) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {7'd0, line_q.pop_front()};
      do @(posedge clk); while (!in_tready);
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_calls(input logic [47:0] d, input logic [47:0] s);
    cur_dest = d;
    cur_src  = s;
    cfg_write(REG_DEST_CALL, {16'd0, d});
    cfg_write(REG_SRC_CALL, {16'd0, s});
  endtask

  function automatic logic [47:0] rand_call();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    if (v[7:0] == FLAG_BYTE) v[0] = 1'b1;
    return v;
  endfunction

  task automatic random_frame();
    int          pick;
    frame_kind_t kind;
    pick = $urandom_range(0, 19);
    if (pick < 12) kind = FR_GOOD;
    else if (pick < 14) kind = FR_BAD_FCS;
    else if (pick < 16) kind = FR_BAD_DEST;
    else if (pick < 18) kind = FR_BAD_SRC;
    else if (pick < 19) kind = FR_FLAG_IN_ADDR;
    else kind = FR_PARTIAL;
    if ($urandom_range(0, 5) == 0) put_noise($urandom_range(5, 30));
    build_frame(kind, $urandom_range(1, 3), $urandom_range(0, 6));
    send_line();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frame under the reset register values
    build_frame(FR_GOOD, 1, 1);
    send_line();
    drain();

    // Extremes: all-zero and all-one calls, offset and length past the frame and the cap
    set_calls(48'h0, 48'hFFFF_FFFF_FFFF);
    cfg_write(REG_PAY_OFF, 64'd63);
    cfg_write(REG_PAY_LEN, 64'd63);
    build_frame(FR_GOOD, 1, 0);
    send_line();
    drain();

    // Last part without idling
    idle_on = 1'b0;
    set_calls(48'hFEFE_FEFE_FEFE, rand_call());
    cfg_write(REG_PAY_OFF, 64'd7);
    cfg_write(REG_PAY_LEN, 64'd48);
    random_frame();
    drain();

    if (fail_count == 0) begin
      $display("[ax25_frame_receiver_unit] OK");
    end else begin
      $display("[ax25_frame_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> ax25_frame_receiver_unit.f
+incdir+rtl/core
rtl/core/ax25_pkg.sv
rtl/core/ax25_front.sv
rtl/core/ax25_desc_fifo.sv
rtl/core/ax25_back.sv
rtl/core/ax25_frame_receiver_unit.sv
rtl/core/ax25_checker.sv
sim/ax25_frame_checker.sv
sim/testbench.sv
